// File: rtl/core/sbd_pkg.sv
package sbd_pkg;

    localparam int EVENT_DEPTH_DEF = 1024;
    localparam int CHANNELS_DEF    = 64;

    localparam int TIME_W      = 32;
    localparam int CH_IN_W     = 6;
    localparam int WIN_W       = 16;
    localparam int REFR_W      = 20;
    localparam int MINS_W      = 11;
    localparam int MINE_W      = 7;
    localparam int PULSE_W     = 16;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int SPK_OUT_W   = 11;
    localparam int ACT_OUT_W   = 7;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int Q_DEPTH     = 4;

    localparam logic [WIN_W-1:0]   WINDOW_RST   = 16'd200;
    localparam logic [REFR_W-1:0]  REFR_RST     = 20'd2400;
    localparam logic [MINS_W-1:0]  MIN_SPK_RST  = 11'd5;
    localparam logic [MINE_W-1:0]  MIN_ELEC_RST = 7'd2;
    localparam logic [PULSE_W-1:0] PULSE_RST    = 16'd1;

    localparam int SPK_SAT = 2047;
    localparam int ACT_SAT = 127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW    = 3'd0,
        REG_REFRACT   = 3'd1,
        REG_MIN_SPK   = 3'd2,
        REG_MIN_ELEC  = 3'd3,
        REG_PULSE     = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        OP_SPIKE = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CH_IN_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic [WIN_W-1:0]   window_ticks;
        logic [REFR_W-1:0]  refractory_ticks;
        logic [MINS_W-1:0]  min_spikes;
        logic [MINE_W-1:0]  min_electrodes;
        logic [PULSE_W-1:0] pulse_ticks;
    } t_cfg;

    // stimulate sits in the lowest bit
    typedef struct packed {
        logic [ACT_OUT_W-1:0] active_electrodes;
        logic [SPK_OUT_W-1:0] spikes_in_window;
        logic                 burst;
        logic                 evaluated;
        logic                 stimulate;
    } t_res;

endpackage

// File: rtl/core/spike_burst_detector_unit.sv
// Spike burst detector.
// Slave stream: one request per spike or tick. s_axis_tuser is the op
// (0 spike, 1 tick), s_axis_tdata[5:0] the electrode channel of a spike.
// Master stream: one result per tick, none per spike. m_axis_tdata holds
// stimulate, evaluated, burst, spikes_in_window[10:0], active_electrodes[6:0]
// from the lowest bit up.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge (0 window, 1 refractory, 2 min spikes, 3 min electrodes,
// 4 pulse length); write only while the block is idle.
// A four-entry request queue sits between intake and the sequencer, so
// requests are taken while a result waits on the master side.
// A spike reads and then writes its channel count in the sequencer, after first
// dropping the oldest event when the ring is full. A tick reads the ring's
// tail, drops each expired event (tail read, check, count read, decrement),
// then evaluates and loads the output register; the event ring and count
// memories have one registered read port each, so each read is its own state.
// Reset (synchronous, i_rst_n low) clears time, ring, channel counts, pulse
// and refractory state and loads the register defaults. When the receiver
// stalls, the result holds in the output register, the sequencer waits and
// the queue fills, after which s_axis_tready falls.
module spike_burst_detector_unit #(
    parameter int EVENT_DEPTH = sbd_pkg::EVENT_DEPTH_DEF,
    parameter int CHANNELS    = sbd_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // channel[5:0], zero pad
    input  logic [0:0]                       s_axis_tuser,  // op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // stimulate, evaluated, burst, spikes_in_window[10:0], active_electrodes[6:0]
    output logic [sbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbd_pkg::CFG_W-1:0]        i_cfg_data
);
    import sbd_pkg::*;

    t_cfg r_cfg;
    t_cmd in_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    t_res res;

    assign in_cmd.op = t_op'(s_axis_tuser[0]);
    assign in_cmd.ch = s_axis_tdata[CH_IN_W-1:0];
    assign m_axis_tdata = {(OUT_TDATA_W - $bits(t_res))'(0), res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks     <= WINDOW_RST;
            r_cfg.refractory_ticks <= REFR_RST;
            r_cfg.min_spikes       <= MIN_SPK_RST;
            r_cfg.min_electrodes   <= MIN_ELEC_RST;
            r_cfg.pulse_ticks      <= PULSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW:   r_cfg.window_ticks     <= i_cfg_data[WIN_W-1:0];
                REG_REFRACT:  r_cfg.refractory_ticks <= i_cfg_data[REFR_W-1:0];
                REG_MIN_SPK:  r_cfg.min_spikes       <= i_cfg_data[MINS_W-1:0];
                REG_MIN_ELEC: r_cfg.min_electrodes   <= i_cfg_data[MINE_W-1:0];
                REG_PULSE:    r_cfg.pulse_ticks      <= i_cfg_data[PULSE_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    sbd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (in_cmd),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    sbd_back #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .CHANNELS    (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

endmodule

// File: rtl/core/sbd_front.sv
module sbd_front #(
    parameter int CHANNELS = sbd_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbd_pkg::t_cmd i_cmd,
    output logic          o_q_valid,
    output sbd_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import sbd_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             keep;
    logic             push;
    logic             pop;

    // drop spikes on channels the block does not have
    assign keep      = (i_cmd.op == OP_TICK) || (32'(i_cmd.ch) < CHANNELS);
    assign o_ready   = (r_cnt != CNT_W'(Q_DEPTH));
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = o_q_valid && i_q_pop;
    assign o_q_cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/sbd_back.sv
module sbd_back #(
    parameter int EVENT_DEPTH = sbd_pkg::EVENT_DEPTH_DEF,
    parameter int CHANNELS    = sbd_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbd_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  sbd_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output sbd_pkg::t_res o_res
);
    import sbd_pkg::*;

    localparam int AW     = $clog2(EVENT_DEPTH);
    localparam int FILL_W = $clog2(EVENT_DEPTH + 1);
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int ACT_W  = $clog2(CHANNELS + 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_RD_TAIL = 9'b000000010,
        S_CHK     = 9'b000000100,
        S_RD_CNT  = 9'b000001000,
        S_DEC     = 9'b000010000,
        S_SPK_RD  = 9'b000100000,
        S_SPK_WR  = 9'b001000000,
        S_EVAL    = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    t_state              r_state;
    logic                r_is_tick;
    logic [CH_W-1:0]     r_ch;
    logic [TIME_W-1:0]   r_time;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_tail;
    logic [FILL_W-1:0]   r_fill;
    logic [ACT_W-1:0]    r_active;
    logic [PULSE_W-1:0]  r_pulse;
    logic [TIME_W-1:0]   r_refr_end;
    logic                r_stim;
    logic                r_refr;
    logic [CHANNELS-1:0] r_cnt_vld;
    t_res                r_res;
    t_res                r_out;
    logic                r_out_vld;

    logic [TIME_W-1:0]   ev_time_mem [EVENT_DEPTH];
    logic [CH_W-1:0]     ev_ch_mem   [EVENT_DEPTH];
    logic [FILL_W-1:0]   cnt_mem     [CHANNELS];

    logic [TIME_W-1:0]   r_ev_time_q;
    logic [CH_W-1:0]     r_ev_ch_q;
    logic [FILL_W-1:0]   r_cnt_q;
    logic                r_cnt_vq;

    logic [CH_W-1:0]     cnt_raddr;
    logic [FILL_W-1:0]   cnt_cur;
    logic [TIME_W-1:0]   age;
    logic                expire;
    logic                full;
    logic [AW-1:0]       tail_next;
    logic [AW-1:0]       head_next;
    logic                out_load;

    logic [PULSE_W-1:0]  e_pulse;
    logic                e_stim;
    logic                e_refr;
    logic [TIME_W-1:0]   e_refr_end;
    logic                e_eval;
    logic                e_burst;

    assign cnt_raddr = (r_state == S_RD_CNT) ? r_ev_ch_q : r_ch;
    assign cnt_cur   = r_cnt_vq ? r_cnt_q : '0;
    assign age       = r_time - r_ev_time_q;
    assign expire    = (age >= TIME_W'(i_cfg.window_ticks));
    assign full      = (r_fill == FILL_W'(EVENT_DEPTH));
    assign tail_next = (r_tail == AW'(EVENT_DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign head_next = (r_head == AW'(EVENT_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign out_load  = (r_state == S_OUT) && (!r_out_vld || i_res_ready);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    // event ring, read port follows the tail
    always_ff @(posedge i_clk) begin
        if (r_state == S_SPK_WR) begin
            ev_time_mem[r_head] <= r_time;
            ev_ch_mem[r_head]   <= r_ch;
        end
        r_ev_time_q <= ev_time_mem[r_tail];
        r_ev_ch_q   <= ev_ch_mem[r_tail];
    end

    // per-channel counts; an entry without its valid bit reads as zero
    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC && cnt_cur != '0) begin
            cnt_mem[r_ev_ch_q] <= cnt_cur - FILL_W'(1);
        end else if (r_state == S_SPK_WR) begin
            cnt_mem[r_ch] <= cnt_cur + FILL_W'(1);
        end
        r_cnt_q  <= cnt_mem[cnt_raddr];
        r_cnt_vq <= r_cnt_vld[cnt_raddr];
    end

    always_comb begin
        e_pulse    = r_pulse;
        e_stim     = r_stim;
        e_refr     = r_refr;
        e_refr_end = r_refr_end;
        e_eval     = 1'b0;
        e_burst    = 1'b0;
        if (r_pulse < i_cfg.pulse_ticks) begin
            e_pulse = r_pulse + PULSE_W'(1);
        end else begin
            e_stim = 1'b0;
        end
        if (r_refr && r_time == r_refr_end) begin
            e_refr = 1'b0;
        end
        if (!e_refr) begin
            e_eval = 1'b1;
            if (32'(r_fill) > 32'(i_cfg.min_spikes)
                    && 32'(r_active) >= 32'(i_cfg.min_electrodes)) begin
                e_burst = 1'b1;
                if (e_pulse >= i_cfg.pulse_ticks) begin
                    e_stim     = 1'b1;
                    e_pulse    = '0;
                    e_refr_end = r_time + TIME_W'(i_cfg.refractory_ticks);
                    e_refr     = (i_cfg.refractory_ticks != '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_is_tick <= (i_q_cmd.op == OP_TICK);
            r_ch      <= CH_W'(i_q_cmd.ch);
        end
        if (r_state == S_EVAL) begin
            r_res.stimulate         <= e_stim;
            r_res.evaluated         <= e_eval;
            r_res.burst             <= e_burst;
            r_res.spikes_in_window  <= (32'(r_fill) > SPK_SAT) ?
                                       SPK_OUT_W'(SPK_SAT) : SPK_OUT_W'(r_fill);
            r_res.active_electrodes <= (32'(r_active) > ACT_SAT) ?
                                       ACT_OUT_W'(ACT_SAT) : ACT_OUT_W'(r_active);
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_time     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_active   <= '0;
            r_pulse    <= PULSE_RST;
            r_refr_end <= '0;
            r_stim     <= 1'b0;
            r_refr     <= 1'b0;
            r_cnt_vld  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_cmd.op == OP_TICK) begin
                            r_time  <= r_time + TIME_W'(1);
                            r_state <= S_RD_TAIL;
                        end else if (full) begin
                            r_state <= S_RD_TAIL;
                        end else begin
                            r_state <= S_SPK_RD;
                        end
                    end
                end
                S_RD_TAIL: begin
                    r_state <= (r_fill == '0) ? S_EVAL : S_CHK;
                end
                S_CHK: begin
                    // a spike into a full ring always drops the oldest event
                    r_state <= (!r_is_tick || expire) ? S_RD_CNT : S_EVAL;
                end
                S_RD_CNT: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (cnt_cur == FILL_W'(1) && r_active != '0) begin
                        r_active <= r_active - ACT_W'(1);
                    end
                    r_tail  <= tail_next;
                    r_fill  <= r_fill - FILL_W'(1);
                    r_state <= r_is_tick ? S_RD_TAIL : S_SPK_RD;
                end
                S_SPK_RD: begin
                    r_state <= S_SPK_WR;
                end
                S_SPK_WR: begin
                    if (cnt_cur == '0) begin
                        r_active <= r_active + ACT_W'(1);
                    end
                    r_cnt_vld[r_ch] <= 1'b1;
                    r_head  <= head_next;
                    r_fill  <= r_fill + FILL_W'(1);
                    r_state <= S_IDLE;
                end
                S_EVAL: begin
                    r_pulse    <= e_pulse;
                    r_stim     <= e_stim;
                    r_refr     <= e_refr;
                    r_refr_end <= e_refr_end;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sbd_checker.sv
module sbd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sbd_pkg::*;

    // no result survives reset
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a burst is only reported on an evaluated tick
    a_burst_evaluated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[2] || m_axis_tdata[1]))
        else $error("burst without evaluation");

    // every active channel holds at least one spike in the window
    a_active_le_spikes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[20:14] <= m_axis_tdata[13:3]))
        else $error("more active channels than spikes");

endmodule

bind spike_burst_detector_unit sbd_checker u_sbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sbd_pkg::*;

    localparam int EVD           = EVENT_DEPTH_DEF;
    localparam int CHN           = CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int FILL_SPIKES   = 1030;
    localparam int DRAIN_LIMIT   = 400000;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {MODE_NORMAL, MODE_PRESSURE, MODE_FILL, MODE_QUIET} t_run_mode;

    typedef struct {
        t_row_kind          kind;
        t_op                op;
        logic [CH_IN_W-1:0] ch;
        t_cfg_reg           idx;
        logic [CFG_W-1:0]   val;
        bit                 typed;
        t_res               want;
    } t_stim_row;

    typedef struct {
        t_cfg      settings;
        int        n_items;
        int        spike_pct;
        t_run_mode mode;
    } t_phase;

    // counts are zero and the window is checked, nothing fires
    localparam t_res IDLE_EVAL_RES = '{active_electrodes: 7'd0, spikes_in_window: 11'd0,
                                       burst: 1'b0, evaluated: 1'b1, stimulate: 1'b0};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // channel[5:0], zero pad
    logic [0:0]             s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // stimulate, evaluated, burst, spikes_in_window[10:0], active_electrodes[6:0]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    spike_burst_detector_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // detector state mirrored for prediction
    t_cfg              cfg;
    logic [31:0]       now_ticks;
    logic [31:0]       ev_time [EVD];
    logic [CH_IN_W-1:0] ev_ch  [EVD];
    int unsigned       head, tail, fill;
    int unsigned       ch_cnt [CHN];
    int unsigned       n_active;
    logic [PULSE_W-1:0] pulse_cnt;
    logic [31:0]       refr_end;
    logic              stim;
    bit                refr_on;

    t_res      pending_results[$];
    t_stim_row stim_rows[$];
    t_phase    phases[$];
    int        errors = 0;
    bit        src_gaps_on;
    bit        quiet_run;
    bit        hold_req;

    function automatic void drop_oldest();
        logic [CH_IN_W-1:0] c;
        c = ev_ch[tail];
        if (ch_cnt[c] > 0) begin
            ch_cnt[c]--;
            if (ch_cnt[c] == 0 && n_active > 0) n_active--;
        end
        tail = (tail + 1 == EVD) ? 0 : tail + 1;
        fill--;
    endfunction

    function automatic void detector_spike(logic [CH_IN_W-1:0] c);
        // full ring: the oldest event goes first
        if (fill >= EVD) drop_oldest();
        ev_time[head] = now_ticks;
        ev_ch[head]   = c;
        head = (head + 1 == EVD) ? 0 : head + 1;
        fill++;
        if (ch_cnt[c] == 0) n_active++;
        ch_cnt[c]++;
    endfunction

    function automatic t_res detector_tick();
        t_res r;
        r = '0;
        now_ticks = now_ticks + 32'd1;
        while (fill != 0 && (now_ticks - ev_time[tail]) >= {16'h0, cfg.window_ticks})
            drop_oldest();
        if (pulse_cnt < cfg.pulse_ticks) pulse_cnt = pulse_cnt + 1'b1;
        else stim = 1'b0;
        if (refr_on && now_ticks == refr_end) refr_on = 1'b0;
        if (!refr_on) begin
            r.evaluated = 1'b1;
            if (fill > cfg.min_spikes && n_active >= cfg.min_electrodes) begin
                r.burst = 1'b1;
                // a pulse still running swallows the trigger
                if (pulse_cnt >= cfg.pulse_ticks) begin
                    stim      = 1'b1;
                    pulse_cnt = '0;
                    refr_end  = now_ticks + {12'h0, cfg.refractory_ticks};
                    refr_on   = (cfg.refractory_ticks != 0);
                end
            end
        end
        r.stimulate         = stim;
        r.spikes_in_window  = SPK_OUT_W'(fill);
        r.active_electrodes = ACT_OUT_W'(n_active);
        return r;
    endfunction

    function automatic void add_req(t_op op, logic [CH_IN_W-1:0] ch);
        t_stim_row row;
        row = '{kind: ROW_REQ, op: op, ch: ch, idx: REG_WINDOW, val: '0, typed: 1'b0,
                want: '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_check(t_op op, logic [CH_IN_W-1:0] ch, t_res want);
        t_stim_row row;
        row = '{kind: ROW_REQ, op: op, ch: ch, idx: REG_WINDOW, val: '0, typed: 1'b1,
                want: want};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        t_stim_row row;
        row = '{kind: ROW_CFG, op: OP_TICK, ch: '0, idx: idx, val: val, typed: 1'b0,
                want: '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_phase(logic [WIN_W-1:0] win, logic [REFR_W-1:0] refr,
                                      logic [MINS_W-1:0] mspk, logic [MINE_W-1:0] melec,
                                      logic [PULSE_W-1:0] pulse, int n, int pct,
                                      t_run_mode m);
        t_phase ph;
        ph.settings.window_ticks     = win;
        ph.settings.refractory_ticks = refr;
        ph.settings.min_spikes       = mspk;
        ph.settings.min_electrodes   = melec;
        ph.settings.pulse_ticks      = pulse;
        ph.n_items   = n;
        ph.spike_pct = pct;
        ph.mode      = m;
        phases.push_back(ph);
    endfunction

    function automatic logic [CH_IN_W-1:0] pick_channel();
        // lean on a few channels so per-channel counts climb
        return ($urandom_range(0, 1) == 0) ? CH_IN_W'($urandom_range(0, 7))
                                            : CH_IN_W'($urandom_range(0, CHN - 1));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= 100)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW:   cfg.window_ticks     = val[WIN_W-1:0];
            REG_REFRACT:  cfg.refractory_ticks = val[REFR_W-1:0];
            REG_MIN_SPK:  cfg.min_spikes       = val[MINS_W-1:0];
            REG_MIN_ELEC: cfg.min_electrodes   = val[MINE_W-1:0];
            REG_PULSE:    cfg.pulse_ticks      = val[PULSE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // spikes give no result; let any still queued finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic issue(t_op op, logic [CH_IN_W-1:0] ch, bit typed, t_res want);
        int   gap;
        t_res r;
        i_cfg_we <= 1'b0;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'(ch);
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_TICK) begin
            r = detector_tick();
            pending_results.push_back(typed ? want : r);
        end else begin
            detector_spike(ch);
        end
    endtask

    initial begin : drive
        bit        prev_cfg;
        t_stim_row row;
        t_phase    ph;
        int        n;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_WINDOW;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        src_gaps_on = 1'b1;
        quiet_run   = 1'b0;
        hold_req    = 1'b0;

        cfg.window_ticks     = WINDOW_RST;
        cfg.refractory_ticks = REFR_RST;
        cfg.min_spikes       = MIN_SPK_RST;
        cfg.min_electrodes   = MIN_ELEC_RST;
        cfg.pulse_ticks      = PULSE_RST;
        now_ticks = '0;
        head = 0;
        tail = 0;
        fill = 0;
        foreach (ch_cnt[c]) ch_cnt[c] = 0;
        n_active  = 0;
        pulse_cnt = PULSE_RST;
        refr_end  = '0;
        stim      = 1'b0;
        refr_on   = 1'b0;

        add_check(OP_TICK, 6'd0, IDLE_EVAL_RES);
        add_cfg(REG_REFRACT, 20'd0);
        add_cfg(REG_MIN_SPK, 20'd0);
        add_cfg(REG_MIN_ELEC, 20'd1);
        add_cfg(REG_PULSE, 20'd3);
        add_req(OP_SPIKE, 6'd0);
        add_req(OP_SPIKE, 6'd63);
        add_req(OP_SPIKE, 6'd63);
        // pulse runs from reset, then triggers, runs again and retriggers
        repeat (6) add_req(OP_TICK, 6'd0);
        // counter now above the new pulse length: stimulate drops
        add_cfg(REG_MIN_ELEC, 20'd64);
        add_cfg(REG_PULSE, 20'd0);
        add_req(OP_TICK, 6'd0);
        // zero window: everything expires on the next tick
        add_cfg(REG_WINDOW, 20'd0);
        add_req(OP_SPIKE, 6'd21);
        add_req(OP_SPIKE, 6'd42);
        add_check(OP_TICK, 6'd0, IDLE_EVAL_RES);

        add_phase(16'd40,    20'd30,      11'd8,    7'd4,   16'd5,     14, 60, MODE_NORMAL);
        add_phase(16'd65535, 20'd1048575, 11'd2047, 7'd127, 16'd65535, 8,  50, MODE_NORMAL);
        add_phase(16'd1,     20'd0,       11'd0,    7'd0,   16'd0,     8,  50, MODE_NORMAL);
        add_phase(16'd20,    20'd5,       11'd3,    7'd2,   16'd50,    12, 55, MODE_NORMAL);
        add_phase(16'd20,    20'd5,       11'd3,    7'd2,   16'd2,     10, 55, MODE_NORMAL);
        add_phase(16'd16,    20'd0,       11'd2,    7'd2,   16'd3,     12, 25, MODE_PRESSURE);
        add_phase(16'd65535, 20'd10,      11'd1023, 7'd64,  16'd4,     8,  40, MODE_FILL);
        add_phase(16'd8,     20'd3,       11'd4,    7'd3,   16'd1,     14, 55, MODE_QUIET);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        prev_cfg = 1'b0;
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                write_reg(row.idx, row.val);
            end else begin
                issue(row.op, row.ch, row.typed, row.want);
            end
            prev_cfg = (row.kind == ROW_CFG);
        end

        foreach (phases[p]) begin
            ph = phases[p];
            settle();
            write_reg(REG_WINDOW,   CFG_W'(ph.settings.window_ticks));
            write_reg(REG_REFRACT,  CFG_W'(ph.settings.refractory_ticks));
            write_reg(REG_MIN_SPK,  CFG_W'(ph.settings.min_spikes));
            write_reg(REG_MIN_ELEC, CFG_W'(ph.settings.min_electrodes));
            write_reg(REG_PULSE,    CFG_W'(ph.settings.pulse_ticks));
            quiet_run   = (ph.mode == MODE_QUIET);
            src_gaps_on = (ph.mode == MODE_NORMAL || ph.mode == MODE_FILL);
            if (ph.mode == MODE_PRESSURE) hold_req = 1'b1;
            if (ph.mode == MODE_FILL) begin
                // sweep every channel first, then overrun the ring
                for (int j = 0; j < FILL_SPIKES; j++)
                    issue(OP_SPIKE, (j < 128) ? CH_IN_W'(j) : pick_channel(), 1'b0, '0);
            end
            for (int i = 0; i < ph.n_items; i++) begin
                if ($urandom_range(0, 99) < ph.spike_pct)
                    issue(OP_SPIKE, pick_channel(), 1'b0, '0);
                else
                    issue(OP_TICK, CH_IN_W'($urandom_range(0, CHN - 1)), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        if (errors == 0) begin
            $display("** spike_burst_detector_unit: PASSED **");
        end else begin
            $display("** spike_burst_detector_unit: FAILED **");
        end
        $finish;
    end

    initial begin : sink
        int gap;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // long hold-off: let the request queue back up
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_res)-1:0];
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", int'(got), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.stimulate != want.stimulate)
                    report_mismatch("stimulate", got.stimulate, want.stimulate);
                if (got.evaluated != want.evaluated)
                    report_mismatch("evaluated", got.evaluated, want.evaluated);
                if (got.burst != want.burst)
                    report_mismatch("burst", got.burst, want.burst);
                if (got.spikes_in_window != want.spikes_in_window)
                    report_mismatch("spikes_in_window", got.spikes_in_window,
                                    want.spikes_in_window);
                if (got.active_electrodes != want.active_electrodes)
                    report_mismatch("active_electrodes", got.active_electrodes,
                                    want.active_electrodes);
            end
        end
    end

    initial begin : watchdog
        #(4_000_000);
        $display("** spike_burst_detector_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sbd_pkg.sv
rtl/core/sbd_front.sv
rtl/core/sbd_back.sv
rtl/core/spike_burst_detector_unit.sv
rtl/core/sbd_checker.sv
dv/testbench.sv
